FILE: src/log_record_ring_packetizer_core_defines.svh
// Assertion macros for the log record ring packetizer
`ifndef LOG_RECORD_RING_PACKETIZER_CORE_DEFINES_SVH
`define LOG_RECORD_RING_PACKETIZER_CORE_DEFINES_SVH
// implication checked on every clock, disabled in reset
`define LRRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lrrp check failed");
// next-cycle implication
`define LRRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lrrp check failed");
`endif

FILE: src/lrrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrp_pkg
// Types and constants of the log record ring packetizer.
// ----------------------------------------------------------------------------
package lrrp_pkg;
    localparam int RING_BYTES = 4096;
    localparam int MAX_LINE   = 120;
    localparam int TOP_LEVEL  = 3;
    localparam int AW = $clog2(RING_BYTES);
    localparam int FW = AW + 1;

    localparam logic [7:0] REC_OVERHEAD = 8'd6;
    localparam logic [7:0] HDR_BYTES    = 8'd4;
    localparam logic [7:0] LEVEL_MASK   = 8'h0F;
    localparam logic [7:0] TRUNC_FLAG   = 8'h80;

    typedef enum logic [2:0] {
        CMD_PUSH_START = 3'd0,
        CMD_PUSH_BYTE  = 3'd1,
        CMD_BEGIN      = 3'd2,
        CMD_READ       = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FILTERED = 2'd1,
        ST_BUSY     = 2'd2,
        ST_NOPKT    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR0  = 4'd1,
        PH_HDR1  = 4'd2,
        PH_HDR2  = 4'd3,
        PH_HDR3  = 4'd4,
        PH_FLAGS = 4'd5,
        PH_TICK0 = 4'd6,
        PH_TICK1 = 4'd7,
        PH_TICK2 = 4'd8,
        PH_TICK3 = 4'd9,
        PH_LEN   = 4'd10,
        PH_TEXT  = 4'd11
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DROP_RD,
        S_DROP_UPD,
        S_WRITE_HDR,
        S_SIZE_RD,
        S_SIZE_UPD,
        S_READ_RD,
        S_READ_UPD,
        S_OUT
    } state_t;

    // memory port request from sequencer
    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [7:0]    wdata;
    } mem_req_t;
endpackage

FILE: src/log_record_ring_packetizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_ring_packetizer_core
// Byte ring of log records with drop-oldest and datagram readout.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low first)                          | tuser
// s_      | in  | command,level,tick_ms,text_length,was_truncated,   | -
//         |     | text_byte,max_bytes,start_seq                      |
// m_      | out | status,payload_byte,packet_length,bytes_pending    | last_byte (tlast)
// cfg     | apb | 0x0 level_threshold                                |
// Work: push_start drops oldest records until the new one fits, then writes
// its six header bytes; begin_packet sizes whole records until one does not
// fit or none is left; ring read_byte beats wait on a ring memory read.
// One ring memory port sets the pace.
// Reset: synchronous, aresetn low; no clearing pass.
// Stalls: s_tready is low while an item is in work or its result waits.
// ----------------------------------------------------------------------------
module log_record_ring_packetizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0] level[6:3] tick_ms[38:7] text_length[46:39]
    // was_truncated[47] text_byte[55:48] max_bytes[63:56] start_seq[79:64]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0] payload_byte[9:2] packet_length[17:10] bytes_pending[30:18]
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lrrp_pkg::*;

    state_t state_reg, state_next;
    logic [79:0] in_reg, in_next;
    logic [AW-1:0] wr_reg, wr_next, old_reg, old_next, p_reg, p_next;
    logic [FW-1:0] fill_reg, fill_next, f_reg, f_next;
    logic [15:0] lost_reg, lost_next, seq_reg, seq_next;
    logic [7:0] trem_reg, trem_next, rrem_reg, rrem_next, held_reg, held_next;
    logic [7:0] off_reg, off_next, len_reg, len_next, flags_reg, flags_next;
    logic [2:0] hcnt_reg, hcnt_next;
    phase_t ph_reg, ph_next;
    logic [3:0] thr_reg;
    logic [1:0] st_reg, st_next;
    logic [7:0] pb_reg, pb_next, pl_reg, pl_next;
    logic last_reg, last_next;
    logic flags_pend_reg;
    mem_req_t req;
    logic [7:0] rdata;

    cmd_t cmd;
    logic [3:0] lvl, lvl_c;
    logic [31:0] tick;
    logic [7:0] tlen, max_b, tbyte;
    logic trunc;
    logic [8:0] rec, need;
    logic [FW:0] room;
    logic [8:0] off_rec;
    logic [15:0] hdr;

    assign cmd   = cmd_t'(in_reg[2:0]);
    assign lvl   = in_reg[6:3];
    assign tick  = in_reg[38:7];
    assign tlen  = in_reg[46:39];
    assign trunc = in_reg[47];
    assign tbyte = in_reg[55:48];
    assign max_b = in_reg[63:56];
    assign lvl_c = (lvl > 4'(TOP_LEVEL)) ? 4'(TOP_LEVEL) : lvl;
    assign rec   = {1'b0, rdata} + {1'b0, REC_OVERHEAD};
    assign need  = {1'b0, len_reg} + {1'b0, REC_OVERHEAD};
    assign room  = (FW+1)'(RING_BYTES) - {1'b0, fill_reg};
    assign off_rec = {1'b0, off_reg} + rec;
    assign hdr = (ph_reg == PH_HDR0 || ph_reg == PH_HDR1) ? seq_reg - 16'd1 : lost_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                state_next = S_OUT;
                if (cmd == CMD_PUSH_START && rrem_reg == 0 && trem_reg == 0
                    && !(lvl_c < thr_reg) && tlen != 0)
                    state_next = S_DROP_RD;
                else if (cmd == CMD_BEGIN && rrem_reg == 0 && trem_reg == 0
                    && max_b >= 8'd11 && fill_reg != 0)
                    state_next = S_SIZE_RD;
                else if (cmd == CMD_READ && rrem_reg != 0 && ph_reg >= PH_FLAGS
                    && ph_reg != PH_LEN)
                    state_next = S_READ_RD;
            end
            S_DROP_RD:  state_next = (fill_reg != 0 && room < (FW+1)'(need))
                                     ? S_DROP_UPD : S_WRITE_HDR;
            S_DROP_UPD: state_next = S_DROP_RD;
            S_WRITE_HDR: if (hcnt_reg == 3'd5) state_next = S_OUT;
            S_SIZE_RD:  state_next = (f_reg != 0) ? S_SIZE_UPD : S_OUT;
            S_SIZE_UPD: state_next = ((FW'(rec) > f_reg) || (off_rec > {1'b0, max_b}))
                                     ? S_OUT : S_SIZE_RD;
            S_READ_RD:  state_next = S_READ_UPD;
            S_READ_UPD: state_next = S_OUT;
            S_OUT:      if (m_tready && !flags_pend_reg) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        in_next = in_reg; wr_next = wr_reg; old_next = old_reg; p_next = p_reg;
        fill_next = fill_reg; f_next = f_reg; lost_next = lost_reg; seq_next = seq_reg;
        trem_next = trem_reg; rrem_next = rrem_reg; held_next = held_reg;
        off_next = off_reg; len_next = len_reg; flags_next = flags_reg;
        hcnt_next = hcnt_reg; ph_next = ph_reg; st_next = st_reg;
        pb_next = pb_reg; pl_next = pl_reg; last_next = last_reg;
        req.we = 1'b0; req.addr = old_reg; req.wdata = 8'd0;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) in_next = s_tdata;
            S_DISPATCH: begin
                st_next = ST_OK; pb_next = 8'd0; pl_next = 8'd0; last_next = 1'b0;
                hcnt_next = 3'd0;
                case (cmd)
                    CMD_PUSH_START: begin
                        len_next = (tlen > 8'(MAX_LINE)) ? 8'(MAX_LINE) : tlen;
                        flags_next = ({4'd0, lvl_c} & LEVEL_MASK)
                            | ((trunc || tlen > 8'(MAX_LINE)) ? TRUNC_FLAG : 8'd0);
                        if (rrem_reg != 0 || trem_reg != 0) st_next = ST_BUSY;
                        else if (lvl_c < thr_reg || tlen == 0) st_next = ST_FILTERED;
                    end
                    CMD_PUSH_BYTE: begin
                        if (rrem_reg != 0) st_next = ST_BUSY;
                        else if (trem_reg != 0) begin
                            req.we = 1'b1; req.addr = wr_reg; req.wdata = tbyte;
                            wr_next = wr_reg + 1'b1; fill_next = fill_reg + 1'b1;
                            trem_next = trem_reg - 8'd1;
                        end
                    end
                    CMD_BEGIN: begin
                        off_next = HDR_BYTES; p_next = old_reg; f_next = fill_reg;
                        if (rrem_reg != 0 || trem_reg != 0) st_next = ST_BUSY;
                        else if (max_b < 8'd11 || fill_reg == 0) st_next = ST_NOPKT;
                    end
                    CMD_READ: begin
                        if (rrem_reg == 0) st_next = ST_NOPKT;
                        else if (ph_reg < PH_FLAGS || ph_reg == PH_LEN) begin
                            if (ph_reg == PH_LEN) begin
                                pb_next = held_reg;
                                old_next = old_reg + AW'(REC_OVERHEAD);
                                fill_next = (fill_reg >= FW'(REC_OVERHEAD))
                                    ? fill_reg - FW'(REC_OVERHEAD) : '0;
                                trem_next = held_reg;
                                ph_next = (held_reg != 0) ? PH_TEXT : PH_FLAGS;
                            end else begin
                                pb_next = (ph_reg == PH_HDR1 || ph_reg == PH_HDR3)
                                    ? hdr[15:8] : hdr[7:0];
                                ph_next = phase_t'(ph_reg + 4'd1);
                            end
                            rrem_next = rrem_reg - 8'd1;
                            if (rrem_reg == 8'd1) begin
                                ph_next = PH_IDLE; trem_next = 8'd0; last_next = 1'b1;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        wr_next = '0; old_next = '0; fill_next = '0; lost_next = '0;
                        trem_next = '0; rrem_next = '0; ph_next = PH_IDLE;
                        held_next = '0; seq_next = in_reg[79:64];
                    end
                    default: ;
                endcase
            end
            S_DROP_RD: req.addr = old_reg;
            S_DROP_UPD: begin
                old_next = old_reg + AW'((FW'(rec) > fill_reg) ? fill_reg : FW'(rec));
                fill_next = (FW'(rec) > fill_reg) ? '0 : fill_reg - FW'(rec);
                lost_next = lost_reg + 16'd1;
            end
            S_WRITE_HDR: begin
                req.we = 1'b1; req.addr = wr_reg;
                case (hcnt_reg)
                    3'd0: req.wdata = len_reg;
                    3'd1: req.wdata = flags_reg;
                    3'd2: req.wdata = tick[7:0];
                    3'd3: req.wdata = tick[15:8];
                    3'd4: req.wdata = tick[23:16];
                    default: req.wdata = tick[31:24];
                endcase
                wr_next = wr_reg + 1'b1; fill_next = fill_reg + 1'b1;
                hcnt_next = hcnt_reg + 3'd1;
                if (hcnt_reg == 3'd5) trem_next = len_reg;
            end
            S_SIZE_RD: begin
                req.addr = p_reg;
                if (f_reg == 0) begin
                    if (off_reg == HDR_BYTES) st_next = ST_NOPKT;
                    else begin
                        seq_next = seq_reg + 16'd1; rrem_next = off_reg;
                        ph_next = PH_HDR0; pl_next = off_reg;
                    end
                end
            end
            S_SIZE_UPD: begin
                if ((FW'(rec) > f_reg) || (off_rec > {1'b0, max_b})) begin
                    if (off_reg == HDR_BYTES) st_next = ST_NOPKT;
                    else begin
                        seq_next = seq_reg + 16'd1; rrem_next = off_reg;
                        ph_next = PH_HDR0; pl_next = off_reg;
                    end
                end else begin
                    off_next = off_rec[7:0]; p_next = p_reg + AW'(rec);
                    f_next = f_reg - FW'(rec);
                end
            end
            S_READ_RD: begin
                if (ph_reg == PH_FLAGS) req.addr = old_reg;
                else if (ph_reg == PH_TEXT) req.addr = old_reg;
                else req.addr = old_reg + AW'(ph_reg - PH_TICK0 + 4'd2);
            end
            S_READ_UPD: begin
                req.addr = old_reg + 1'b1;
                if (ph_reg == PH_FLAGS) begin
                    held_next = rdata;
                    ph_next = PH_TICK0;
                end else if (ph_reg == PH_TEXT) begin
                    pb_next = rdata;
                    old_next = old_reg + 1'b1;
                    if (fill_reg != 0) fill_next = fill_reg - 1'b1;
                    if (trem_reg > 1) trem_next = trem_reg - 8'd1;
                    else begin trem_next = 8'd0; ph_next = PH_FLAGS; end
                end else begin
                    pb_next = rdata;
                    ph_next = phase_t'(ph_reg + 4'd1);
                end
                rrem_next = rrem_reg - 8'd1;
                if (rrem_reg == 8'd1) begin
                    ph_next = PH_IDLE; trem_next = 8'd0; last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // flags byte is read in the cycle after the length byte
    always_ff @(posedge aclk) begin
        if (!aresetn) flags_pend_reg <= 1'b0;
        else flags_pend_reg <= (state_reg == S_READ_UPD) && (ph_reg == PH_FLAGS);
    end
    always_ff @(posedge aclk) begin
        if (flags_pend_reg) pb_reg <= rdata;
        else pb_reg <= pb_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; wr_reg <= '0; old_reg <= '0; fill_reg <= '0;
            lost_reg <= '0; seq_reg <= '0; trem_reg <= '0; rrem_reg <= '0;
            held_reg <= '0; ph_reg <= PH_IDLE; thr_reg <= 4'(TOP_LEVEL);
        end else begin
            state_reg <= state_next; wr_reg <= wr_next; old_reg <= old_next;
            fill_reg <= fill_next; lost_reg <= lost_next; seq_reg <= seq_next;
            trem_reg <= trem_next; rrem_reg <= rrem_next; held_reg <= held_next;
            ph_reg <= ph_next;
            if (psel && penable && pwrite && paddr == 2'd0)
                thr_reg <= (pwdata[3:0] > 4'(TOP_LEVEL)) ? 4'(TOP_LEVEL) : pwdata[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        in_reg <= in_next; p_reg <= p_next; f_reg <= f_next; off_reg <= off_next;
        len_reg <= len_next; flags_reg <= flags_next; hcnt_reg <= hcnt_next;
        st_reg <= st_next; pl_reg <= pl_next; last_reg <= last_next;
    end

    lrrp_ram u_ram (.aclk(aclk), .req(req), .rdata(rdata));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT) && !flags_pend_reg;
    assign m_tdata  = {1'b0, fill_reg, pl_reg, pb_reg, st_reg};
    assign m_tlast  = last_reg;
    assign pready   = 1'b1;
    assign prdata   = {28'd0, thr_reg};
endmodule

FILE: src/lrrp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrrp_ram
// Single-port ring byte store with registered read.
// ----------------------------------------------------------------------------
module lrrp_ram (
    input  logic              aclk,
    input  lrrp_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import lrrp_pkg::*;

    logic [7:0] mem [RING_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: src/lrrp_checker.sv
`timescale 1ns / 1ps
`include "log_record_ring_packetizer_core_defines.svh"
// ----------------------------------------------------------------------------
// lrrp_checker
// Port-level checks of the packetizer.
// ----------------------------------------------------------------------------
module lrrp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    `LRRP_ASSERT_IMP(a_excl, aclk, aresetn, m_tvalid, !s_tready)
    `LRRP_ASSERT_IMP(a_last_ok, aclk, aresetn, m_tvalid && m_tlast, m_tdata[1:0] == 2'd0)
    `LRRP_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LRRP_ASSERT_NXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
endmodule

bind log_record_ring_packetizer_core lrrp_checker u_lrrp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

FILE: bench/log_record_ring_packetizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_ring_packetizer_core_tb
// Drives command beats into the log ring packetizer and predicts every result
// beat (status, payload byte, packet length, fill level, last mark) with a
// behavioral copy of the ring, with random idling on both streams and
// threshold writes over the APB port between phases.
// ----------------------------------------------------------------------------
module log_record_ring_packetizer_core_tb;
    import lrrp_pkg::*;

    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] start_seq;
        logic [7:0]  max_bytes;
        logic [7:0]  text_byte;
        logic        was_truncated;
        logic [7:0]  text_length;
        logic [31:0] tick_ms;
        logic [3:0]  level;
        cmd_t        command;
    } cmd_beat_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_length;
        logic        last_byte;
        logic [12:0] bytes_pending;
    } result_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    log_record_ring_packetizer_core u_top (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // predictor state
    logic [7:0]  ring [RING_BYTES];
    logic [11:0] wr_ptr, old_ptr;
    int          fill, lost, seq_no, txt_left, rd_left, thresh, held_len;
    phase_t      phase;

    cmd_beat_t cmd_q[$];
    result_t   result_q[$];
    int        errors = 0;
    int        idle_pct = 11;
    bit        hold_s = 0;
    int        quiet = 0;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void store_byte(input logic [7:0] b);
        ring[wr_ptr] = b;
        wr_ptr++;
        fill++;
    endfunction

    function automatic void ring_empty();
        wr_ptr = 0; old_ptr = 0; fill = 0; lost = 0;
        txt_left = 0; rd_left = 0; phase = PH_IDLE; held_len = 0;
    endfunction

    function automatic result_t predict_ring(input cmd_beat_t c);
        result_t r;
        int lvl, len, need, rec, off, f, flg;
        logic [11:0] p;
        logic [15:0] hdr;
        bit tr;
        r = '0;
        r.status = ST_OK;
        case (c.command)
            CMD_PUSH_START: begin
                lvl = c.level; len = c.text_length; tr = c.was_truncated;
                if (rd_left != 0 || txt_left != 0) r.status = ST_BUSY;
                else begin
                    if (lvl > TOP_LEVEL) lvl = TOP_LEVEL;
                    if (len > MAX_LINE) begin
                        len = MAX_LINE; tr = 1;
                    end
                    if (lvl < thresh || len == 0) r.status = ST_FILTERED;
                    else begin
                        flg = (lvl & LEVEL_MASK) | (tr ? TRUNC_FLAG : 0);
                        need = REC_OVERHEAD + len;
                        while (fill > 0 && RING_BYTES - fill < need) begin
                            rec = REC_OVERHEAD + ring[old_ptr];
                            if (rec > fill) rec = fill;
                            old_ptr += 12'(rec);
                            fill -= rec;
                            lost = (lost + 1) & 16'hFFFF;
                        end
                        store_byte(8'(len)); store_byte(8'(flg));
                        store_byte(c.tick_ms[7:0]); store_byte(c.tick_ms[15:8]);
                        store_byte(c.tick_ms[23:16]); store_byte(c.tick_ms[31:24]);
                        txt_left = len;
                    end
                end
            end
            CMD_PUSH_BYTE: begin
                if (rd_left != 0) r.status = ST_BUSY;
                else if (txt_left != 0) begin
                    store_byte(c.text_byte);
                    txt_left--;
                end
            end
            CMD_BEGIN: begin
                off = HDR_BYTES; p = old_ptr; f = fill;
                if (rd_left != 0 || txt_left != 0) r.status = ST_BUSY;
                else if (c.max_bytes < HDR_BYTES + REC_OVERHEAD + 1 || fill == 0)
                    r.status = ST_NOPKT;
                else begin
                    while (f > 0) begin
                        rec = REC_OVERHEAD + ring[p];
                        if (rec > f || off + rec > c.max_bytes) break;
                        off += rec; p += 12'(rec); f -= rec;
                    end
                    if (off == HDR_BYTES) r.status = ST_NOPKT;
                    else begin
                        seq_no = (seq_no + 1) & 16'hFFFF;
                        rd_left = off; phase = PH_HDR0;
                        r.packet_length = 8'(off);
                    end
                end
            end
            CMD_READ: begin
                if (rd_left == 0) r.status = ST_NOPKT;
                else begin
                    if (phase >= PH_HDR0 && phase < PH_FLAGS) begin
                        hdr = (phase < PH_HDR2) ? 16'(seq_no - 1) : 16'(lost);
                        r.payload_byte = (phase == PH_HDR1 || phase == PH_HDR3) ?
                                         hdr[15:8] : hdr[7:0];
                        phase = phase_t'(phase + 1);
                    end else if (phase == PH_FLAGS) begin
                        held_len = ring[old_ptr];
                        r.payload_byte = ring[12'(old_ptr + 1)];
                        phase = PH_TICK0;
                    end else if (phase >= PH_TICK0 && phase < PH_LEN) begin
                        r.payload_byte = ring[12'(old_ptr + 2 + (phase - PH_TICK0))];
                        phase = phase_t'(phase + 1);
                    end else if (phase == PH_LEN) begin
                        r.payload_byte = 8'(held_len);
                        old_ptr += 12'(REC_OVERHEAD);
                        fill = fill >= REC_OVERHEAD ? fill - REC_OVERHEAD : 0;
                        txt_left = held_len;
                        phase = txt_left != 0 ? PH_TEXT : PH_FLAGS;
                    end else begin
                        r.payload_byte = ring[old_ptr];
                        old_ptr++;
                        if (fill > 0) fill--;
                        if (txt_left > 0) txt_left--;
                        if (txt_left == 0) phase = PH_FLAGS;
                    end
                    rd_left--;
                    if (rd_left == 0) begin
                        phase = PH_IDLE; txt_left = 0; r.last_byte = 1;
                    end
                end
            end
            CMD_CLEAR: begin
                ring_empty();
                seq_no = c.start_seq;
            end
            default: ;
        endcase
        r.bytes_pending = 13'(fill);
        return r;
    endfunction

    function automatic cmd_beat_t rand_beat(input cmd_t op);
        cmd_beat_t c;
        c = cmd_beat_t'(80'({$urandom, $urandom, $urandom}));
        c.command = op;
        return c;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                result_q.push_back(predict_ring(cmd_beat_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() > 0 && !hold_s && $urandom_range(99) >= idle_pct) begin
                    s_tdata  <= cmd_q.pop_front();
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn) begin
            m_tready <= $urandom_range(99) >= idle_pct;
            if (m_tvalid && m_tready) begin
                got = '{status_t'(m_tdata[1:0]), m_tdata[9:2], m_tdata[17:10],
                        m_tlast, m_tdata[30:18]};
                if (result_q.size() == 0) report("result beat with none expected");
                else begin
                    want = result_q.pop_front();
                    if (got.status !== want.status)
                        report($sformatf("status %0d exp %0d", got.status, want.status));
                    if (got.payload_byte !== want.payload_byte)
                        report($sformatf("payload %h exp %h", got.payload_byte,
                                         want.payload_byte));
                    if (got.packet_length !== want.packet_length)
                        report($sformatf("length %0d exp %0d", got.packet_length,
                                         want.packet_length));
                    if (got.last_byte !== want.last_byte)
                        report($sformatf("last %b exp %b", got.last_byte, want.last_byte));
                    if (got.bytes_pending !== want.bytes_pending)
                        report($sformatf("fill %0d exp %0d", got.bytes_pending,
                                         want.bytes_pending));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WD_LIMIT) begin
            $display("FAIL log_record_ring_packetizer_core");
            $finish;
        end
    end

    task automatic apb_write(input logic [3:0] v);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= v; penable <= 0;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        thresh = v > TOP_LEVEL ? TOP_LEVEL : v;
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || s_tvalid || result_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic add_record(input int lvl, input int len);
        cmd_beat_t c;
        c = rand_beat(CMD_PUSH_START);
        c.level = 4'(lvl); c.text_length = 8'(len);
        cmd_q.push_back(c);
        repeat (len) cmd_q.push_back(rand_beat(CMD_PUSH_BYTE));
    endtask

    task automatic add_packet(input int mx);
        cmd_beat_t c;
        c = rand_beat(CMD_BEGIN);
        c.max_bytes = 8'(mx);
        cmd_q.push_back(c);
        repeat (mx) cmd_q.push_back(rand_beat(CMD_READ));
    endtask

    initial begin
        cmd_beat_t c;
        int n, k;
        for (int i = 0; i < RING_BYTES; i++) ring[i] = 0;
        ring_empty();
        seq_no = 0;
        thresh = TOP_LEVEL;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // directed
        apb_write(4'd0);
        c = rand_beat(CMD_READ); cmd_q.push_back(c);
        c = rand_beat(CMD_BEGIN); c.max_bytes = 8'd255; cmd_q.push_back(c);
        c = rand_beat(CMD_PUSH_BYTE); cmd_q.push_back(c);
        add_record(15, 255);
        c = rand_beat(CMD_PUSH_START); cmd_q.push_back(c);
        c = rand_beat(CMD_BEGIN); cmd_q.push_back(c);
        add_record(0, 0);
        add_record(2, 1);
        c = rand_beat(CMD_BEGIN); c.max_bytes = 8'd10; cmd_q.push_back(c);
        c = rand_beat(CMD_BEGIN); c.max_bytes = 8'd11; cmd_q.push_back(c);
        c = rand_beat(CMD_PUSH_START); cmd_q.push_back(c);
        c = rand_beat(CMD_PUSH_BYTE); cmd_q.push_back(c);
        c = rand_beat(CMD_BEGIN); cmd_q.push_back(c);
        repeat (3) cmd_q.push_back(rand_beat(CMD_READ));
        c = rand_beat(CMD_CLEAR); c.start_seq = 16'hFFFF; cmd_q.push_back(c);
        c = rand_beat(CMD_CLEAR); c.command = cmd_t'(3'd7); cmd_q.push_back(c);
        drain();

        // sender held with commands queued, then released
        hold_s = 1;
        add_record(3, 5);
        repeat (30) @(posedge aclk);
        hold_s = 0;
        drain();

        apb_write(4'd15);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 1) idle_pct = 0;
            else idle_pct = 11;
            n = cmd_q.size();
            for (int i = 0; i < 120; i++) begin
                k = $urandom_range(99);
                if (k < 55) add_record($urandom_range(15), $urandom_range(255));
                else if (k < 80) add_packet($urandom_range(255));
                else if (k < 83) begin
                    c = rand_beat(CMD_CLEAR); cmd_q.push_back(c);
                end else begin
                    c = rand_beat(cmd_t'(3'($urandom_range(7)))); cmd_q.push_back(c);
                end
                if (cmd_q.size() - n > 330) break;
            end
            drain();
            apb_write(ph == 0 ? 4'd1 : (ph == 1 ? 4'd2 : 4'd0));
        end
        apb_write(4'd3);
        drain();

        if (errors == 0) begin
            $display("PASS log_record_ring_packetizer_core");
        end else begin
            $display("FAIL log_record_ring_packetizer_core");
        end
        $finish;
    end
endmodule
